// ===== hdl/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the multi-button debouncer
// Register indexes, reset values and the control/event bundles exchanged
// between the top level and the per-button cells.
// ----------------------------------------------------------------------------
package mbd_pkg;

    // Configuration register indexes
    localparam logic REG_SETTLE_TICKS = 1'b0;
    localparam logic REG_ENABLE_MASK  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] RESET_SETTLE = 8'd5;
    localparam logic [7:0] RESET_ENABLE = 8'd3;

    // Most events one tick can produce; larger room values clamp here
    localparam logic [3:0] MAX_ROOM = 4'd8;

    // Request type codes
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic       tick;    // tick transfer this cycle: lower countdowns
        logic       shift;   // scan token moves one cell down the chain
        logic [7:0] settle;  // countdown load value for edges
    } cell_ctl_t;

    // Event offered by the cell that holds the scan token
    typedef struct packed {
        logic emit;
        logic released;
    } cell_evt_t;

endpackage

// ===== hdl/mbd_cell.sv =====
// ----------------------------------------------------------------------------
// mbd_cell: state of one button and one stage of the scan chain
// Holds the pending mark, settle countdown and debounced level of a button,
// and passes the scan token with the remaining output room to its neighbor.
// ----------------------------------------------------------------------------
module mbd_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbd_pkg::cell_ctl_t  ctl,
    input  logic                edge_hit,
    input  logic                enable,
    input  logic                level,
    input  logic                tok_in,
    input  logic [3:0]          room_in,
    output logic                tok_out,
    output logic [3:0]          room_out,
    output mbd_pkg::cell_evt_t  evt
);

    logic       tok_reg,     tok_next;
    logic [3:0] room_reg,    room_next;
    logic       pending_reg, pending_next;
    logic [7:0] count_reg,   count_next;
    logic       stable_reg,  stable_next;

    logic at_zero;
    logic act;
    logic differs;
    logic emit;
    logic retry;

    // Scan decision for this button while it holds the token
    assign at_zero = (count_reg == 8'd0);
    assign act     = tok_reg & enable & pending_reg & at_zero;
    assign differs = (level != stable_reg);
    assign emit    = act & differs & (room_reg != 4'd0);
    assign retry   = act & differs & (room_reg == 4'd0);

    assign tok_out      = tok_reg;
    assign room_out     = room_reg - {3'd0, emit};
    assign evt.emit     = emit;
    assign evt.released = level;

    // Next state
    always_comb begin
        tok_next     = ctl.shift ? tok_in : tok_reg;
        room_next    = ctl.shift ? room_in : room_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        stable_next  = stable_reg;
        if (edge_hit && enable) begin
            count_next   = ctl.settle;
            pending_next = 1'b1;
        end else if (ctl.tick && enable && !at_zero) begin
            count_next = count_reg - 8'd1;
        end else if (ctl.shift && act) begin
            if (retry) begin
                // no room: sample again on the next tick
                count_next = 8'd1;
            end else begin
                pending_next = 1'b0;
            end
            if (emit) begin
                stable_next = level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg     <= 1'b0;
            pending_reg <= 1'b0;
            count_reg   <= 8'd0;
            stable_reg  <= 1'b1;
        end else begin
            tok_reg     <= tok_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            stable_reg  <= stable_next;
        end
    end

    // Room travels with the token; no reset needed
    always_ff @(posedge aclk) begin
        room_reg <= room_next;
    end

endmodule

// ===== hdl/multi_button_debouncer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_button_debouncer_unit: settle-timer debouncer for up to 8 buttons
// Edge transfers restart an enabled button's countdown; tick transfers lower
// enabled countdowns and scan the buttons in index order, emitting press/release
// events limited by the supplied queue room.
// ----------------------------------------------------------------------------
//  channel  | ports                                               | direction
//  ---------+-----------------------------------------------------+----------
//  s_       | s_valid/s_ready, req_type, button_index, pin_levels, | in
//           | queue_room                                          |
//  m_       | m_valid/m_ready, event_button, event_released,      | out
//           | event_last                                          |
//  cfg_     | cfg_wr_en, cfg_index, cfg_wdata                      | in
//
// In a tick transfer a token walks the chain of button cells one cell per
// cycle unless stalled. s_ready is low while a tick scan runs. A stalled m_
// channel holds the token in place when its holder has an event while one
// event waits in the output register and one in the hold stage. Reset
// (aresetn, synchronous) marks all buttons released, idle.
// ----------------------------------------------------------------------------
module multi_button_debouncer_unit #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [2:0] s_button_index,
    input  logic [7:0] s_pin_levels,
    input  logic [3:0] s_queue_room,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_button,
    output logic       m_event_released,
    output logic       m_event_last,
    // configuration
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] settle_reg, mask_reg;
    logic [7:0] pins_reg;
    logic       busy_reg,   busy_next;
    logic       hold_valid_reg, hold_valid_next;
    logic [2:0] hold_button_reg, hold_button_next;
    logic       hold_released_reg, hold_released_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_button_reg, m_button_next;
    logic       m_released_reg, m_released_next;
    logic       m_last_reg, m_last_next;

    logic                s_fire;
    logic                tick_fire;
    logic [3:0]          room_clamped;
    logic [NUM_BUTTONS:0] tok_chain;
    logic [3:0]          room_chain [NUM_BUTTONS+1];
    logic [NUM_BUTTONS-1:0] edge_hit;
    logic [NUM_BUTTONS-1:0] tok_cells;
    mbd_pkg::cell_evt_t  evt [NUM_BUTTONS];
    mbd_pkg::cell_ctl_t  ctl;

    logic       emit_any;
    logic [2:0] ev_button;
    logic       ev_released;
    logic       tok_any;
    logic       out_free;
    logic       stall;

    // Handshake and broadcast control
    assign s_ready   = !busy_reg;
    assign s_fire    = s_valid && s_ready;
    assign tick_fire = s_fire && (s_req_type == mbd_pkg::REQ_TICK);
    assign room_clamped = (s_queue_room > mbd_pkg::MAX_ROOM) ? mbd_pkg::MAX_ROOM
                                                             : s_queue_room;
    assign out_free  = !m_valid_reg || m_ready;
    assign stall     = emit_any && hold_valid_reg && !out_free;

    assign ctl.tick   = tick_fire;
    assign ctl.shift  = !stall;
    assign ctl.settle = settle_reg;

    assign tok_chain[0]  = tick_fire;
    assign room_chain[0] = room_clamped;
    assign tok_any       = |tok_cells;

    // Edge decode
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            edge_hit[i] = s_fire && (s_req_type == mbd_pkg::REQ_EDGE)
                          && (32'(s_button_index) == i);
        end
    end

    // Button cells
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
        logic en_g;
        logic lvl_g;
        if (g < 8) begin : g_mapped
            assign en_g  = mask_reg[g];
            assign lvl_g = pins_reg[g];
        end else begin : g_unmapped
            assign en_g  = 1'b0;
            assign lvl_g = 1'b0;
        end
        mbd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .edge_hit (edge_hit[g]),
            .enable   (en_g),
            .level    (lvl_g),
            .tok_in   (tok_chain[g]),
            .room_in  (room_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .room_out (room_chain[g+1]),
            .evt      (evt[g])
        );
        assign tok_cells[g] = tok_chain[g+1];
    end

    // Gather the event of the token holder
    always_comb begin
        emit_any    = 1'b0;
        ev_button   = 3'd0;
        ev_released = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (evt[i].emit) begin
                emit_any    = 1'b1;
                ev_button   = 3'(i);
                ev_released = evt[i].released;
            end
        end
    end

    // Hold stage and output register: an event waits in hold until the next
    // event or the end of the scan tells whether it is the last one
    always_comb begin
        busy_next          = busy_reg;
        hold_valid_next    = hold_valid_reg;
        hold_button_next   = hold_button_reg;
        hold_released_next = hold_released_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_button_next      = m_button_reg;
        m_released_next    = m_released_reg;
        m_last_next        = m_last_reg;
        if (tick_fire) begin
            busy_next = 1'b1;
        end else if (busy_reg && tok_any) begin
            if (emit_any && !stall) begin
                if (hold_valid_reg) begin
                    m_valid_next    = 1'b1;
                    m_button_next   = hold_button_reg;
                    m_released_next = hold_released_reg;
                    m_last_next     = 1'b0;
                end
                hold_valid_next    = 1'b1;
                hold_button_next   = ev_button;
                hold_released_next = ev_released;
            end
        end else if (busy_reg) begin
            // scan finished: flush the final event with the last mark
            if (!hold_valid_reg) begin
                busy_next = 1'b0;
            end else if (out_free) begin
                m_valid_next    = 1'b1;
                m_button_next   = hold_button_reg;
                m_released_next = hold_released_reg;
                m_last_next     = 1'b1;
                hold_valid_next = 1'b0;
                busy_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_button_reg   <= hold_button_next;
        hold_released_reg <= hold_released_next;
        m_button_reg      <= m_button_next;
        m_released_reg    <= m_released_next;
        m_last_reg        <= m_last_next;
        if (tick_fire) begin
            pins_reg <= s_pin_levels;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= mbd_pkg::RESET_SETTLE;
            mask_reg   <= mbd_pkg::RESET_ENABLE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbd_pkg::REG_SETTLE_TICKS: settle_reg <= cfg_wdata;
                mbd_pkg::REG_ENABLE_MASK:  mask_reg   <= cfg_wdata;
                default:                   settle_reg <= settle_reg;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_button   = m_button_reg;
    assign m_event_released = m_released_reg;
    assign m_event_last     = m_last_reg;

endmodule
